### rtl/core/bnic_pkg.sv
// Shared types, constants and register indexes for the backlight controller.
package bnic_pkg;

    localparam int unsigned CFG_ADDR_W  = 3;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned IN_TDATA_W  = 88;
    localparam int unsigned IN_TUSER_W  = 2;
    localparam int unsigned OUT_TDATA_W = 16;
    localparam int unsigned DELAY_W     = 24;

    localparam logic [39:0] CLOCK_EPOCH_MIN = 40'd1609459200;
    localparam logic [15:0] MS_PER_MINUTE   = 16'd60000;
    localparam logic [31:0] CHECK_PERIOD_MS = 32'd1000;

    localparam logic [10:0] NIGHT_START_RST = 11'd1320;
    localparam logic [10:0] NIGHT_END_RST   = 11'd420;
    localparam logic [7:0]  NIGHT_LEVEL_RST = 8'd32;
    localparam logic [7:0]  DAY_LEVEL_RST   = 8'd255;
    localparam logic [31:0] TOUCH_WAKE_RST  = 32'd30000;

    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_TOUCH   = 2'd1,
        REQ_MANUAL  = 2'd2,
        REQ_REFRESH = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        CFG_NIGHT_ENABLE   = 3'd0,
        CFG_NIGHT_SLEEP    = 3'd1,
        CFG_NIGHT_START    = 3'd2,
        CFG_NIGHT_END      = 3'd3,
        CFG_NIGHT_LEVEL    = 3'd4,
        CFG_DAY_LEVEL      = 3'd5,
        CFG_OFFLINE_MIN    = 3'd6,
        CFG_TOUCH_WAKE     = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic                night_enable;
        logic                night_forces_sleep;
        logic [10:0]         night_start_minute;
        logic [10:0]         night_end_minute;
        logic [7:0]          night_level;
        logic [7:0]          day_level;
        logic [DELAY_W-1:0]  offline_delay_ms;
        logic [31:0]         wake_hold_ms;
    } cfg_t;

    typedef struct packed {
        req_t        req_type;
        logic [31:0] now_ms;
        logic [39:0] epoch_seconds;
        logic [10:0] minute_of_day;
        logic        screen_sleep_eligible;
        logic        host_online;
        logic        off_request;
    } item_t;

    typedef struct packed {
        logic [7:0] backlight_level;
        logic       level_changed;
        logic       evaluated;
        logic       night_active;
        logic       offline_sleeping;
        logic       time_valid;
        logic       manual_off;
        logic       sleeping_for_touch;
    } result_t;

endpackage

### rtl/core/bnic_cfg.sv
// Configuration register file with precomputed offline sleep delay.
module bnic_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [bnic_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [bnic_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output bnic_pkg::cfg_t                    cfg
);
    import bnic_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                CFG_NIGHT_ENABLE: cfg_next.night_enable       = cfg_wdata[0];
                CFG_NIGHT_SLEEP:  cfg_next.night_forces_sleep = cfg_wdata[0];
                CFG_NIGHT_START:  cfg_next.night_start_minute = cfg_wdata[10:0];
                CFG_NIGHT_END:    cfg_next.night_end_minute   = cfg_wdata[10:0];
                CFG_NIGHT_LEVEL:  cfg_next.night_level        = cfg_wdata[7:0];
                CFG_DAY_LEVEL:    cfg_next.day_level          = cfg_wdata[7:0];
                CFG_OFFLINE_MIN:  cfg_next.offline_delay_ms   =
                    DELAY_W'(cfg_wdata[7:0]) * DELAY_W'(MS_PER_MINUTE);
                CFG_TOUCH_WAKE:   cfg_next.wake_hold_ms       = cfg_wdata[31:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.night_enable       <= 1'b0;
            cfg_reg.night_forces_sleep <= 1'b0;
            cfg_reg.night_start_minute <= NIGHT_START_RST;
            cfg_reg.night_end_minute   <= NIGHT_END_RST;
            cfg_reg.night_level        <= NIGHT_LEVEL_RST;
            cfg_reg.day_level          <= DAY_LEVEL_RST;
            cfg_reg.offline_delay_ms   <= '0;
            cfg_reg.wake_hold_ms       <= TOUCH_WAKE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/core/bnic_rule.sv
// Control state and single-pass evaluation of one item.
module bnic_rule (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  bnic_pkg::item_t   item,
    input  bnic_pkg::cfg_t    cfg,
    output bnic_pkg::result_t res
);
    import bnic_pkg::*;

    logic [7:0]  applied_reg,   applied_next;
    logic        night_reg,     night_next;
    logic        sleep_reg,     sleep_next;
    logic        clock_ok_reg,  clock_ok_next;
    logic        tracking_reg,  tracking_next;
    logic        pending_reg,   pending_next;
    logic        manual_reg,    manual_next;
    logic [31:0] since_reg,     since_next;
    logic [31:0] last_reg,      last_next;
    logic [31:0] wake_reg,      wake_next;

    logic [31:0] wake_diff;
    logic        wake_active;
    logic        clock_ok;
    logic        win_raw;
    logic        window;
    logic        night_eval;
    logic        offline;
    logic [31:0] since_eff;
    logic [31:0] elapsed;
    logic        sleep_eval;
    logic [7:0]  target;
    logic        tick_due;
    logic        evaluated;
    logic        changed;

    assign wake_diff   = wake_reg - item.now_ms;
    assign wake_active = (wake_reg != '0) && (wake_diff != '0) && !wake_diff[31];
    assign clock_ok    = item.epoch_seconds >= CLOCK_EPOCH_MIN;

    always_comb
    begin
        if (cfg.night_start_minute < cfg.night_end_minute)
            win_raw = (item.minute_of_day >= cfg.night_start_minute) &&
                      (item.minute_of_day < cfg.night_end_minute);
        else if (cfg.night_start_minute > cfg.night_end_minute)
            win_raw = (item.minute_of_day >= cfg.night_start_minute) ||
                      (item.minute_of_day < cfg.night_end_minute);
        else
            win_raw = 1'b0;
    end

    assign window     = clock_ok && (cfg.night_enable || cfg.night_forces_sleep) && win_raw;
    assign night_eval = cfg.night_enable && window;
    assign offline    = item.screen_sleep_eligible && !item.host_online;
    assign since_eff  = tracking_reg ? since_reg : item.now_ms;
    assign elapsed    = item.now_ms - since_eff;
    assign sleep_eval = offline && !wake_active &&
        (((cfg.offline_delay_ms != '0) && (elapsed >= 32'(cfg.offline_delay_ms))) ||
         (cfg.night_forces_sleep && window));
    assign target     = (sleep_eval || manual_reg) ? 8'd0 :
                        (night_eval ? cfg.night_level : cfg.day_level);
    assign tick_due   = pending_reg || ((item.now_ms - last_reg) >= CHECK_PERIOD_MS);

    always_comb
    begin
        applied_next  = applied_reg;
        night_next    = night_reg;
        sleep_next    = sleep_reg;
        clock_ok_next = clock_ok_reg;
        tracking_next = tracking_reg;
        pending_next  = pending_reg;
        manual_next   = manual_reg;
        since_next    = since_reg;
        last_next     = last_reg;
        wake_next     = wake_reg;
        evaluated     = 1'b0;
        changed       = 1'b0;
        case (item.req_type)
            REQ_TICK:
            begin
                if (tick_due)
                begin
                    evaluated     = 1'b1;
                    pending_next  = 1'b0;
                    last_next     = item.now_ms;
                    wake_next     = wake_active ? wake_reg : 32'd0;
                    clock_ok_next = clock_ok;
                    night_next    = night_eval;
                    tracking_next = offline;
                    since_next    = offline ? since_eff : since_reg;
                    sleep_next    = sleep_eval;
                    changed       = target != applied_reg;
                    applied_next  = target;
                end
            end
            REQ_TOUCH:
            begin
                manual_next  = 1'b0;
                wake_next    = item.now_ms + cfg.wake_hold_ms;
                pending_next = 1'b1;
            end
            REQ_MANUAL:
            begin
                manual_next  = item.off_request;
                wake_next    = item.off_request ? 32'd0 : wake_reg;
                pending_next = 1'b1;
            end
            REQ_REFRESH:
            begin
                pending_next = 1'b1;
            end
            default:
            begin
                pending_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            applied_reg  <= '0;
            night_reg    <= 1'b0;
            sleep_reg    <= 1'b0;
            clock_ok_reg <= 1'b0;
            tracking_reg <= 1'b0;
            pending_reg  <= 1'b1;
            manual_reg   <= 1'b0;
            since_reg    <= '0;
            last_reg     <= '0;
            wake_reg     <= '0;
        end
        else if (advance)
        begin
            applied_reg  <= applied_next;
            night_reg    <= night_next;
            sleep_reg    <= sleep_next;
            clock_ok_reg <= clock_ok_next;
            tracking_reg <= tracking_next;
            pending_reg  <= pending_next;
            manual_reg   <= manual_next;
            since_reg    <= since_next;
            last_reg     <= last_next;
            wake_reg     <= wake_next;
        end
    end

    assign res.backlight_level    = applied_next;
    assign res.level_changed      = changed;
    assign res.evaluated          = evaluated;
    assign res.night_active       = night_next;
    assign res.offline_sleeping   = sleep_next;
    assign res.time_valid         = clock_ok_next;
    assign res.manual_off         = manual_next;
    assign res.sleeping_for_touch = manual_next || sleep_next;

endmodule

### rtl/core/backlight_night_and_idle_controller.sv
// Top level: input register, evaluation stage and output register.
// A result passes the input register and then the output register before it is valid on the master side.
// Throughput: one item per cycle unless the output stalls, which also holds off the input register.
// Evaluation is one pass of compares between the input and output registers.
// Reset (rst_n low, asynchronous) clears the valid flags of both stages, the control state and the
// configuration registers to their default values; no clearing pass is needed.
module backlight_night_and_idle_controller (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // now_ms, epoch_seconds, minute_of_day, screen_sleep_eligible, host_online,
    // off_request, zero fill
    input  logic [bnic_pkg::IN_TDATA_W-1:0]    s_tdata,
    // req_type
    input  logic [bnic_pkg::IN_TUSER_W-1:0]    s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // backlight_level, level_changed, evaluated, night_active, offline_sleeping,
    // time_valid, manual_off, sleeping_for_touch, zero fill
    output logic [bnic_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                               cfg_we,
    input  logic [bnic_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [bnic_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import bnic_pkg::*;

    cfg_t    cfg;
    item_t   in_item;
    item_t   in_reg;
    logic    in_vld_reg, in_vld_next;
    result_t res;
    result_t out_reg;
    logic    out_vld_reg, out_vld_next;
    logic    advance;
    logic    s_accept;

    assign in_item.req_type              = req_t'(s_tuser);
    assign in_item.now_ms                = s_tdata[31:0];
    assign in_item.epoch_seconds         = s_tdata[71:32];
    assign in_item.minute_of_day         = s_tdata[82:72];
    assign in_item.screen_sleep_eligible = s_tdata[83];
    assign in_item.host_online           = s_tdata[84];
    assign in_item.off_request           = s_tdata[85];

    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign in_vld_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_vld_reg);
    assign out_vld_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_vld_reg);

    bnic_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bnic_rule u_rule (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_reg <= in_item;
        end
        if (advance)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {1'b0,
                       out_reg.sleeping_for_touch,
                       out_reg.manual_off,
                       out_reg.time_valid,
                       out_reg.offline_sleeping,
                       out_reg.night_active,
                       out_reg.evaluated,
                       out_reg.level_changed,
                       out_reg.backlight_level};

endmodule

### rtl/core/bnic_checker.sv
// Port-level checks on the result stream, bound to the top level.
module bnic_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [bnic_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import bnic_pkg::*;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    a_touch_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[14] == (m_tdata[13] || m_tdata[11])))
        else $error("sleeping_for_touch disagrees with manual_off and offline_sleeping");

    a_change_needs_eval: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[8] |-> m_tdata[9])
        else $error("level changed without evaluation");

    a_off_is_dark: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[9] && (m_tdata[13] || m_tdata[11]) |-> (m_tdata[7:0] == 8'd0))
        else $error("nonzero level while display is off or asleep after evaluation");

endmodule

bind backlight_night_and_idle_controller bnic_checker u_bnic_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### verif/backlight_night_and_idle_controller_checker.sv
// Checker for the backlight controller: predicts each status item and compares it.
module backlight_night_and_idle_controller_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    // now_ms, epoch_seconds, minute_of_day, screen_sleep_eligible, host_online,
    // off_request, zero fill
    input  logic [bnic_pkg::IN_TDATA_W-1:0]  s_tdata,
    // req_type
    input  logic [bnic_pkg::IN_TUSER_W-1:0]  s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    // backlight_level, level_changed, evaluated, night_active, offline_sleeping,
    // time_valid, manual_off, sleeping_for_touch, zero fill
    input  logic [bnic_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                             cfg_we,
    input  logic [bnic_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [bnic_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                               pending_results,
    output int                               results_checked,
    output int                               mismatch_count
);
    import bnic_pkg::*;

    logic        c_night_en;
    logic        c_night_sleep;
    logic [10:0] c_start;
    logic [10:0] c_end;
    logic [7:0]  c_night_level;
    logic [7:0]  c_day_level;
    logic [7:0]  c_offline_min;
    logic [31:0] c_touch_ms;

    logic [7:0]  level;
    logic        night_on;
    logic        asleep;
    logic        clock_ok;
    logic        tracking;
    logic        refresh_due;
    logic        man_off;
    logic [31:0] offline_start;
    logic [31:0] last_eval_ms;
    logic [31:0] wake_deadline;

    result_t     expected_status[$];

    task automatic predict_backlight(input item_t it, output result_t r);
        logic [31:0] wake_left;
        logic [31:0] delay_ms;
        logic        wake_on;
        logic        window;
        logic        due;
        logic        ran;
        logic        changed;
        logic [7:0]  target;
        ran = 1'b0;
        changed = 1'b0;
        case (it.req_type)
            REQ_TICK:
            begin
                if (refresh_due || (it.now_ms - last_eval_ms) >= CHECK_PERIOD_MS)
                begin
                    refresh_due = 1'b0;
                    last_eval_ms = it.now_ms;
                    ran = 1'b1;
                    wake_left = wake_deadline - it.now_ms;
                    wake_on = (wake_deadline != 0) && (wake_left != 0) && !wake_left[31];
                    if (!wake_on)
                        wake_deadline = '0;
                    clock_ok = it.epoch_seconds >= CLOCK_EPOCH_MIN;
                    window = 1'b0;
                    if (clock_ok && (c_night_en || c_night_sleep))
                    begin
                        if (c_start < c_end)
                            window = (it.minute_of_day >= c_start) && (it.minute_of_day < c_end);
                        else if (c_start > c_end)
                            window = (it.minute_of_day >= c_start) || (it.minute_of_day < c_end);
                    end
                    night_on = c_night_en && window;
                    if (!it.screen_sleep_eligible || it.host_online)
                    begin
                        tracking = 1'b0;
                        asleep = 1'b0;
                    end
                    else
                    begin
                        if (!tracking)
                        begin
                            tracking = 1'b1;
                            offline_start = it.now_ms;
                        end
                        delay_ms = 32'(c_offline_min) * 32'(MS_PER_MINUTE);
                        due = ((delay_ms != 0) && (it.now_ms - offline_start) >= delay_ms)
                              || (c_night_sleep && window);
                        asleep = due && !wake_on;
                    end
                    target = night_on ? c_night_level : c_day_level;
                    if (asleep || man_off)
                        target = '0;
                    if (target != level)
                    begin
                        level = target;
                        changed = 1'b1;
                    end
                end
            end
            REQ_TOUCH:
            begin
                man_off = 1'b0;
                wake_deadline = it.now_ms + c_touch_ms;
                refresh_due = 1'b1;
            end
            REQ_MANUAL:
            begin
                man_off = it.off_request;
                if (man_off)
                    wake_deadline = '0;
                refresh_due = 1'b1;
            end
            default:
                refresh_due = 1'b1;
        endcase
        r.backlight_level    = level;
        r.level_changed      = changed;
        r.evaluated          = ran;
        r.night_active       = night_on;
        r.offline_sleeping   = asleep;
        r.time_valid         = clock_ok;
        r.manual_off         = man_off;
        r.sleeping_for_touch = man_off || asleep;
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        item_t   it;
        if (!rst_n)
        begin
            c_night_en    = 1'b0;
            c_night_sleep = 1'b0;
            c_start       = NIGHT_START_RST;
            c_end         = NIGHT_END_RST;
            c_night_level = NIGHT_LEVEL_RST;
            c_day_level   = DAY_LEVEL_RST;
            c_offline_min = '0;
            c_touch_ms    = TOUCH_WAKE_RST;
            level         = '0;
            night_on      = 1'b0;
            asleep        = 1'b0;
            clock_ok      = 1'b0;
            tracking      = 1'b0;
            refresh_due   = 1'b1;
            man_off       = 1'b0;
            offline_start = '0;
            last_eval_ms  = '0;
            wake_deadline = '0;
            expected_status.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.backlight_level    = m_tdata[7:0];
                got.level_changed      = m_tdata[8];
                got.evaluated          = m_tdata[9];
                got.night_active       = m_tdata[10];
                got.offline_sleeping   = m_tdata[11];
                got.time_valid         = m_tdata[12];
                got.manual_off         = m_tdata[13];
                got.sleeping_for_touch = m_tdata[14];
                if (expected_status.size() == 0)
                begin
                    mismatch_count++;
                    $error("unexpected status item 0x%0h", m_tdata);
                end
                else
                begin
                    want = expected_status.pop_front();
                    results_checked++;
                    compare_field("backlight_level", want.backlight_level, got.backlight_level);
                    compare_field("level_changed", 8'(want.level_changed),
                                  8'(got.level_changed));
                    compare_field("evaluated", 8'(want.evaluated), 8'(got.evaluated));
                    compare_field("night_active", 8'(want.night_active),
                                  8'(got.night_active));
                    compare_field("offline_sleeping", 8'(want.offline_sleeping),
                                  8'(got.offline_sleeping));
                    compare_field("time_valid", 8'(want.time_valid), 8'(got.time_valid));
                    compare_field("manual_off", 8'(want.manual_off), 8'(got.manual_off));
                    compare_field("sleeping_for_touch", 8'(want.sleeping_for_touch),
                                  8'(got.sleeping_for_touch));
                end
            end
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_addr))
                    CFG_NIGHT_ENABLE: c_night_en    = cfg_wdata[0];
                    CFG_NIGHT_SLEEP:  c_night_sleep = cfg_wdata[0];
                    CFG_NIGHT_START:  c_start       = cfg_wdata[10:0];
                    CFG_NIGHT_END:    c_end         = cfg_wdata[10:0];
                    CFG_NIGHT_LEVEL:  c_night_level = cfg_wdata[7:0];
                    CFG_DAY_LEVEL:    c_day_level   = cfg_wdata[7:0];
                    CFG_OFFLINE_MIN:  c_offline_min = cfg_wdata[7:0];
                    CFG_TOUCH_WAKE:   c_touch_ms    = cfg_wdata[31:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                it.req_type              = req_t'(s_tuser);
                it.now_ms                = s_tdata[31:0];
                it.epoch_seconds         = s_tdata[71:32];
                it.minute_of_day         = s_tdata[82:72];
                it.screen_sleep_eligible = s_tdata[83];
                it.host_online           = s_tdata[84];
                it.off_request           = s_tdata[85];
                predict_backlight(it, want);
                expected_status.push_back(want);
            end
        end
        pending_results = expected_status.size();
    end

endmodule

### verif/backlight_night_and_idle_controller_tb.sv
// Testbench top for the backlight controller: stimulus, idling, watchdog and verdict.
module backlight_night_and_idle_controller_tb;
    import bnic_pkg::*;

    localparam int STALL_LIMIT  = 5000;
    localparam int PHASE_ITEMS  = 400;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [IN_TUSER_W-1:0]  s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    int          pending_results;
    int          results_checked;
    int          mismatch_count;
    int          src_idle_pct;
    int          sink_idle_pct;
    int          req_seen [4];
    logic [31:0] clock_ms;
    logic        host_up;
    logic        screen_can_sleep;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    backlight_night_and_idle_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    backlight_night_and_idle_controller_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .pending_results (pending_results),
        .results_checked (results_checked),
        .mismatch_count  (mismatch_count)
    );

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= sink_idle_pct);

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic apply_setting(input logic en, input logic forces, input logic [10:0] start_min,
                                 input logic [10:0] end_min, input logic [7:0] dim_level,
                                 input logic [7:0] full_level, input logic [7:0] off_min,
                                 input logic [31:0] wake_ms);
        write_reg(CFG_NIGHT_ENABLE, 32'(en));
        write_reg(CFG_NIGHT_SLEEP, 32'(forces));
        write_reg(CFG_NIGHT_START, 32'(start_min));
        write_reg(CFG_NIGHT_END, 32'(end_min));
        write_reg(CFG_NIGHT_LEVEL, 32'(dim_level));
        write_reg(CFG_DAY_LEVEL, 32'(full_level));
        write_reg(CFG_OFFLINE_MIN, 32'(off_min));
        write_reg(CFG_TOUCH_WAKE, wake_ms);
    endtask

    task automatic send_item(input req_t req, input logic [31:0] now, input logic [39:0] epoch,
                             input logic [10:0] minute, input logic elig, input logic online,
                             input logic off);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {2'b00, off, online, elig, minute, epoch, now};
        req_seen[req]++;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_random_item();
        req_t        req;
        logic [39:0] epoch;
        logic [10:0] minute;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 70)
            req = REQ_TICK;
        else if (pick < 80)
            req = REQ_TOUCH;
        else if (pick < 90)
            req = REQ_MANUAL;
        else
            req = REQ_REFRESH;
        pick = $urandom_range(99);
        if (pick < 3)
            clock_ms = $urandom;
        else if (pick < 8)
            clock_ms = clock_ms + $urandom_range(100000, 5000000);
        else
            clock_ms = clock_ms + $urandom_range(0, 1500);
        pick = $urandom_range(99);
        if (pick < 70)
            epoch = CLOCK_EPOCH_MIN + 40'($urandom_range(0, 400000000));
        else if (pick < 80)
            epoch = 40'($urandom_range(0, 1609459199));
        else if (pick < 85)
            epoch = CLOCK_EPOCH_MIN - 40'($urandom_range(1));
        else
            epoch = {8'($urandom_range(255)), 32'($urandom)};
        if ($urandom_range(99) < 92)
            minute = 11'($urandom_range(0, 1439));
        else
            minute = 11'($urandom_range(1440, 2047));
        if ($urandom_range(99) < 10)
            host_up = !host_up;
        if ($urandom_range(99) < 10)
            screen_can_sleep = !screen_can_sleep;
        send_item(req, clock_ms, epoch, minute, screen_can_sleep, host_up,
                  1'($urandom_range(1)));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    initial
    begin
        int stall_cycles;
        stall_cycles = 0;
        @(posedge rst_n);
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rst_n            = 1'b0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        s_tuser          = REQ_TICK;
        m_tready         = 1'b0;
        cfg_we           = 1'b0;
        cfg_addr         = CFG_NIGHT_ENABLE;
        cfg_wdata        = '0;
        src_idle_pct     = 0;
        sink_idle_pct    = 0;
        clock_ms         = '0;
        host_up          = 1'b0;
        screen_can_sleep = 1'b1;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // wrapping night window, epoch bounds, tick gating, manual off, touch wrapping to zero
        apply_setting(1'b1, 1'b0, 11'd1320, 11'd420, 8'd32, 8'd255, 8'd0, 32'd30000);
        send_item(REQ_TICK, 32'd0, 40'd0, 11'd0, 1'b0, 1'b1, 1'b0);
        send_item(REQ_TICK, 32'd500, CLOCK_EPOCH_MIN, 11'd1320, 1'b0, 1'b1, 1'b0);
        send_item(REQ_TICK, 32'd1000, CLOCK_EPOCH_MIN, 11'd1320, 1'b0, 1'b1, 1'b0);
        send_item(REQ_TICK, 32'd2000, 40'hFF_FFFF_FFFF, 11'd419, 1'b0, 1'b1, 1'b0);
        send_item(REQ_TICK, 32'd3000, CLOCK_EPOCH_MIN, 11'd420, 1'b0, 1'b1, 1'b0);
        send_item(REQ_TICK, 32'd4000, CLOCK_EPOCH_MIN, 11'd2047, 1'b0, 1'b1, 1'b0);
        send_item(REQ_TICK, 32'd5000, CLOCK_EPOCH_MIN - 40'd1, 11'd1400, 1'b0, 1'b1, 1'b0);
        send_item(REQ_REFRESH, 32'd5100, CLOCK_EPOCH_MIN, 11'd1400, 1'b1, 1'b1, 1'b1);
        send_item(REQ_TICK, 32'd5200, CLOCK_EPOCH_MIN, 11'd1400, 1'b1, 1'b1, 1'b0);
        send_item(REQ_MANUAL, 32'd5300, CLOCK_EPOCH_MIN, 11'd1400, 1'b1, 1'b1, 1'b1);
        send_item(REQ_TICK, 32'd5400, CLOCK_EPOCH_MIN, 11'd1400, 1'b1, 1'b1, 1'b0);
        send_item(REQ_MANUAL, 32'd5500, CLOCK_EPOCH_MIN, 11'd1400, 1'b1, 1'b1, 1'b0);
        send_item(REQ_TICK, 32'd5600, CLOCK_EPOCH_MIN, 11'd1400, 1'b1, 1'b1, 1'b0);
        send_item(REQ_TOUCH, 32'hFFFF_8AD0, CLOCK_EPOCH_MIN, 11'd0, 1'b1, 1'b0, 1'b0);
        send_item(REQ_TICK, 32'hFFFF_FFFF, CLOCK_EPOCH_MIN, 11'd0, 1'b1, 1'b0, 1'b0);
        wait_idle();

        // empty window, longest offline timer, shortest touch wake
        apply_setting(1'b0, 1'b1, 11'd600, 11'd600, 8'd255, 8'd0, 8'd255, 32'd1);
        send_item(REQ_REFRESH, 32'd0, CLOCK_EPOCH_MIN, 11'd600, 1'b1, 1'b0, 1'b0);
        send_item(REQ_TICK, 32'd0, CLOCK_EPOCH_MIN, 11'd600, 1'b1, 1'b0, 1'b0);
        send_item(REQ_TOUCH, 32'd10, CLOCK_EPOCH_MIN, 11'd600, 1'b1, 1'b0, 1'b0);
        send_item(REQ_TICK, 32'd10, CLOCK_EPOCH_MIN, 11'd600, 1'b1, 1'b0, 1'b0);
        wait_idle();

        // night forces sleep, offline timer due, longest touch wake lands in the past
        apply_setting(1'b1, 1'b1, 11'd100, 11'd200, 8'd0, 8'd128, 8'd1, 32'hFFFF_FFFF);
        send_item(REQ_REFRESH, 32'd100, CLOCK_EPOCH_MIN, 11'd150, 1'b1, 1'b0, 1'b0);
        send_item(REQ_TICK, 32'd100, CLOCK_EPOCH_MIN, 11'd150, 1'b1, 1'b0, 1'b0);
        send_item(REQ_TICK, 32'd70000, CLOCK_EPOCH_MIN, 11'd300, 1'b1, 1'b0, 1'b0);
        send_item(REQ_TOUCH, 32'd70001, CLOCK_EPOCH_MIN, 11'd300, 1'b1, 1'b0, 1'b0);
        send_item(REQ_TICK, 32'd70002, CLOCK_EPOCH_MIN, 11'd300, 1'b1, 1'b0, 1'b0);
        send_item(REQ_MANUAL, 32'd70003, CLOCK_EPOCH_MIN, 11'd300, 1'b1, 1'b0, 1'b1);
        wait_idle();

        clock_ms = 32'd80000;
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct  = 15;
                    sink_idle_pct = 85;
                    apply_setting(1'b1, 1'b0, 11'd1320, 11'd420, 8'($urandom_range(255)),
                                  8'd255, 8'd1, 32'd30000);
                end
                1:
                begin
                    src_idle_pct  = 85;
                    sink_idle_pct = 15;
                    apply_setting(1'b1, 1'b1, 11'd0, 11'd1439, 8'd0, 8'($urandom_range(255)),
                                  8'd2, 32'd5000);
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                    apply_setting(1'($urandom_range(1)), 1'b1, 11'd1439, 11'd0, 8'd255, 8'd0,
                                  8'($urandom_range(3)), 32'($urandom_range(1, 60000)));
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random_item();
            wait_idle();
        end

        $display("Sent %0d ticks, %0d touches, %0d manual requests and %0d refreshes",
                 req_seen[REQ_TICK], req_seen[REQ_TOUCH], req_seen[REQ_MANUAL],
                 req_seen[REQ_REFRESH]);
        $display("across six register settings and three stall patterns; %0d items checked",
                 results_checked);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
